[src/stw_pkg.sv]
// stw_pkg: shared types and constants of the stereo winner-take-all block
// no dependencies; used by the interfaces, the scan unit, the top level and the checker
`default_nettype none

package stw_pkg;

	// fixed field widths of the channels
	localparam int COST_W = 16;
	localparam int PIX_W  = 6;
	localparam int DISP_W = 7;
	localparam int STAT_W = 2;

	// configuration register indexes (paddr[3:2])
	localparam logic [1:0] REG_MIN_DISP  = 2'd0;
	localparam logic [1:0] REG_MAX_DISP  = 2'd1;
	localparam logic [1:0] REG_ROW_WIDTH = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_TIE = 2'd1;
	localparam logic [STAT_W-1:0] ST_LRF = 2'd2;

	// scan unit operations
	typedef logic [1:0] scan_mode_t;
	localparam scan_mode_t MODE_MIN = 2'd0;
	localparam scan_mode_t MODE_TIE = 2'd1;
	localparam scan_mode_t MODE_LR  = 2'd2;

	typedef struct packed {
		logic       clr;
		scan_mode_t mode;
		logic       vld;
	} scan_ctrl_t;

	typedef struct packed {
		logic tie;
		logic lr;
	} scan_flags_t;

endpackage

`default_nettype wire

[src/stw_ifs.sv]
// stw_ifs: valid/ready channel interfaces for cost beats and result beats
// depends on stw_pkg for the field widths
`default_nettype none

interface stw_in_if;
	import stw_pkg::*;
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] cost;
	logic              row_last;

	modport source (output valid, output cost, output row_last, input ready);
	modport sink   (input valid, input cost, input row_last, output ready);
endinterface

interface stw_out_if;
	import stw_pkg::*;
	logic                     valid;
	logic                     ready;
	logic        [PIX_W-1:0]  pixel_index;
	logic signed [DISP_W-1:0] disparity;
	logic        [STAT_W-1:0] status;
	logic                     last_of_row;

	modport source (output valid, output pixel_index, output disparity, output status,
		output last_of_row, input ready);
	modport sink   (input valid, input pixel_index, input disparity, input status,
		input last_of_row, output ready);
endinterface

`default_nettype wire

[src/stw_cost_mem.sv]
// stw_cost_mem: cost store, one write port and one registered read port
// no package dependency
`default_nettype none

module stw_cost_mem #(
	parameter int AW = 12,
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[src/stw_scan_unit.sv]
// stw_scan_unit: shared compare unit for minimum search, tie scan and cross check
// depends on stw_pkg for the control and flag structs
`default_nettype none

module stw_scan_unit #(
	parameter int DW = 16,
	parameter int KW = 6
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  stw_pkg::scan_ctrl_t       ctrl,
	input  wire logic        [DW-1:0] data,
	input  wire logic        [KW-1:0] tag,
	output logic             [KW-1:0] kbest,
	output stw_pkg::scan_flags_t      flags
);
	import stw_pkg::*;

	logic [DW-1:0] best_q;
	logic [KW-1:0] kbest_q;
	logic          tie_q;
	logic          lr_q;
	logic          lt;
	logic          eq;

	// the one comparator pair, shared by every phase
	assign lt = data < best_q;
	assign eq = data == best_q;

	always_ff @(posedge clk) begin
		if (ctrl.vld && ctrl.mode == MODE_MIN && (tag == '0 || lt)) begin
			best_q  <= data;
			kbest_q <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tie_q <= 1'b0;
			lr_q  <= 1'b0;
		end else if (ctrl.clr) begin
			tie_q <= 1'b0;
			lr_q  <= 1'b0;
		end else if (ctrl.vld) begin
			case (ctrl.mode)
				MODE_TIE: begin
					if (tag != kbest_q && eq) begin
						tie_q <= 1'b1;
					end
				end
				MODE_LR: begin
					if (lt) begin
						lr_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign kbest     = kbest_q;
	assign flags.tie = tie_q;
	assign flags.lr  = lr_q;

endmodule

`default_nettype wire

[src/stereo_wta_lr_check.sv]
// stereo_wta_lr_check: top level, cost loading, scan sequencer, apb registers, result register
// depends on stw_pkg, stw_ifs, stw_cost_mem and stw_scan_unit
//
// channel     dir  beat                          handshake
// cost_in     in   cost, row_last                valid/ready
// result_out  out  pixel_index, disparity,       valid/ready
//                  status, last_of_row
// apb         in   min_disp, max_disp, row_width psel/penable, pready tied high
//
// loading: cost beats are taken only while idle and may follow back to back
// after the row_last beat every pixel is scanned with one read of the cost memory
// per cycle, in order: minimum search, tie scan, and unless tied cross check, then the
// emit step hands the result to the output register; the single read port and the one
// shared compare unit make these phases run one after another
// cost_in is not ready during the scan; a stalled result holds the scan in its emit step
// reset: registers go to -30 / 30 / 64, load position to zero; the cost memory has no
// clearing pass
`default_nettype none

module stereo_wta_lr_check #(
	parameter int MAX_WIDTH = 64,
	parameter int NUM_DISP  = 64,
	parameter int COST_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	stw_in_if.sink           cost_in,
	stw_out_if.source        result_out,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import stw_pkg::*;

	// pixel and disparity slot index widths, counts that can hold the full size
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int KW = (NUM_DISP > 1) ? $clog2(NUM_DISP) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int SW = $clog2(NUM_DISP + 1);
	localparam int CW = ((XW > KW) ? XW : KW) + 1;
	localparam int AW = XW + KW;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MIN  = 3'd1;
	localparam logic [2:0] S_TIE  = 3'd2;
	localparam logic [2:0] S_LR   = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	// configuration registers
	logic [6:0] min_disp_q;
	logic [6:0] max_disp_q;
	logic [6:0] row_width_q;

	// load position
	logic [XW-1:0] lp_q;
	logic [KW-1:0] lk_q;

	// sequencer
	logic [2:0]    state_q;
	logic [XW-1:0] x_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] lim_q;
	logic          iss_q;
	logic          rd_vld_q;
	logic [KW-1:0] tag_q;

	// result register
	logic              ov_q;
	logic [PIX_W-1:0]  opix_q;
	logic [DISP_W-1:0] odisp_q;
	logic [STAT_W-1:0] ostat_q;
	logic              olast_q;

	logic signed [7:0] diff;
	logic        [7:0] span_raw;
	logic     [SW-1:0] span_c;
	logic     [WW-1:0] w_c;
	logic              in_acc;
	logic              wrap;
	logic     [XW-1:0] cur_p;
	logic     [KW-1:0] cur_k;
	logic        [7:0] k_inc;
	logic        [7:0] p_inc;
	logic     [XW-1:0] nxt_p;
	logic     [KW-1:0] nxt_k;
	logic              drained;
	logic              emit_go;
	logic              last_px;
	logic              clr_c;
	logic     [CW-1:0] span_m1;
	logic     [CW-1:0] sum_c;
	logic     [CW-1:0] lr_start;
	logic     [CW-1:0] lr_end;
	logic     [CW-1:0] kk_full;
	logic     [AW-1:0] raddr;
	logic [COST_BITS-1:0] rdata;
	logic     [KW-1:0] kbest;
	logic        [7:0] dsum;
	logic              apb_wr;
	scan_ctrl_t        ctrl;
	scan_flags_t       flags;

	// apb register port
	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_disp_q  <= 7'h62;
			max_disp_q  <= 7'd30;
			row_width_q <= 7'd64;
		end else if (apb_wr) begin
			case (paddr[3:2])
				REG_MIN_DISP:  min_disp_q  <= pwdata[6:0];
				REG_MAX_DISP:  max_disp_q  <= pwdata[6:0];
				REG_ROW_WIDTH: row_width_q <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MIN_DISP:  prdata = {{25{min_disp_q[6]}}, min_disp_q};
			REG_MAX_DISP:  prdata = {{25{max_disp_q[6]}}, max_disp_q};
			REG_ROW_WIDTH: prdata = {25'd0, row_width_q};
			default:       prdata = '0;
		endcase
	end

	// effective span: empty range searches min_disp alone, wide range saturates
	assign diff = $signed({max_disp_q[6], max_disp_q}) - $signed({min_disp_q[6], min_disp_q});

	always_comb begin
		if (diff[7]) begin
			span_raw = 8'd1;
		end else begin
			span_raw = 8'(diff) + 8'd1;
		end
		if (span_raw > 8'(NUM_DISP)) begin
			span_c = SW'(NUM_DISP);
		end else begin
			span_c = SW'(span_raw);
		end
	end

	// effective row width clamped to 1..MAX_WIDTH
	always_comb begin
		if (row_width_q == 7'd0) begin
			w_c = WW'(1);
		end else if (row_width_q > 7'(MAX_WIDTH)) begin
			w_c = WW'(MAX_WIDTH);
		end else begin
			w_c = WW'(row_width_q);
		end
	end

	// cost loading: a position outside the current row or span wraps to the origin
	assign cost_in.ready = (state_q == S_IDLE);
	assign in_acc        = cost_in.valid && cost_in.ready;
	assign wrap          = (8'(lp_q) >= 8'(w_c)) || (8'(lk_q) >= 8'(span_c));
	assign cur_p         = wrap ? '0 : lp_q;
	assign cur_k         = wrap ? '0 : lk_q;
	assign k_inc         = 8'(cur_k) + 8'd1;
	assign p_inc         = 8'(cur_p) + 8'd1;

	always_comb begin
		if (k_inc >= 8'(span_c)) begin
			nxt_k = '0;
			if (p_inc >= 8'(w_c)) begin
				nxt_p = '0;
			end else begin
				nxt_p = XW'(p_inc);
			end
		end else begin
			nxt_k = KW'(k_inc);
			nxt_p = cur_p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
			lk_q <= '0;
		end else if (in_acc) begin
			if (cost_in.row_last) begin
				lp_q <= '0;
				lk_q <= '0;
			end else begin
				lp_q <= nxt_p;
				lk_q <= nxt_k;
			end
		end
	end

	// scan ranges
	assign drained  = !iss_q && !rd_vld_q;
	assign emit_go  = (state_q == S_EMIT) && (!ov_q || result_out.ready);
	assign last_px  = (8'(x_q) + 8'd1 == 8'(w_c));
	assign clr_c    = (in_acc && cost_in.row_last) || (emit_go && !last_px);
	assign span_m1  = CW'(span_c) - CW'(1);
	// left pixel i maps onto the same right column at slot x + kbest - i
	assign sum_c    = CW'(x_q) + CW'(kbest);
	assign lr_start = (sum_c >= span_m1) ? (sum_c - span_m1) : '0;
	assign lr_end   = (sum_c > CW'(w_c) - CW'(1)) ? (CW'(w_c) - CW'(1)) : sum_c;
	assign kk_full  = sum_c - cnt_q;

	always_comb begin
		if (state_q == S_LR) begin
			raddr = {cnt_q[XW-1:0], kk_full[KW-1:0]};
		end else begin
			raddr = {x_q, cnt_q[KW-1:0]};
		end
	end

	// sequencer: issues one memory read a cycle, moves on once the read pipe drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			x_q      <= '0;
			cnt_q    <= '0;
			lim_q    <= '0;
			iss_q    <= 1'b0;
			rd_vld_q <= 1'b0;
			tag_q    <= '0;
		end else begin
			rd_vld_q <= iss_q;
			tag_q    <= cnt_q[KW-1:0];
			if (iss_q) begin
				if (cnt_q == lim_q) begin
					iss_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && cost_in.row_last) begin
						x_q     <= '0;
						cnt_q   <= '0;
						lim_q   <= span_m1;
						iss_q   <= 1'b1;
						state_q <= S_MIN;
					end
				end
				S_MIN: begin
					if (drained) begin
						cnt_q   <= '0;
						lim_q   <= span_m1;
						iss_q   <= 1'b1;
						state_q <= S_TIE;
					end
				end
				S_TIE: begin
					if (drained) begin
						if (flags.tie) begin
							state_q <= S_EMIT;
						end else begin
							cnt_q   <= lr_start;
							lim_q   <= lr_end;
							iss_q   <= 1'b1;
							state_q <= S_LR;
						end
					end
				end
				S_LR: begin
					if (drained) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						if (last_px) begin
							state_q <= S_IDLE;
						end else begin
							x_q     <= x_q + XW'(1);
							cnt_q   <= '0;
							lim_q   <= span_m1;
							iss_q   <= 1'b1;
							state_q <= S_MIN;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	stw_cost_mem #(
		.AW(AW),
		.DW(COST_BITS)
	) u_mem (
		.clk  (clk),
		.we   (in_acc),
		.waddr({cur_p, cur_k}),
		.wdata(COST_BITS'(cost_in.cost)),
		.re   (iss_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_comb begin
		ctrl.clr = clr_c;
		ctrl.vld = rd_vld_q;
		case (state_q)
			S_TIE:   ctrl.mode = MODE_TIE;
			S_LR:    ctrl.mode = MODE_LR;
			default: ctrl.mode = MODE_MIN;
		endcase
	end

	stw_scan_unit #(
		.DW(COST_BITS),
		.KW(KW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (ctrl),
		.data  (rdata),
		.tag   (tag_q),
		.kbest (kbest),
		.flags (flags)
	);

	// result register, decouples the scan from a stalled sink
	assign dsum = {min_disp_q[6], min_disp_q} + 8'(kbest);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (emit_go) begin
			ov_q <= 1'b1;
		end else if (result_out.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			opix_q  <= PIX_W'(x_q);
			odisp_q <= dsum[DISP_W-1:0];
			olast_q <= last_px;
			if (flags.tie) begin
				ostat_q <= ST_TIE;
			end else if (flags.lr) begin
				ostat_q <= ST_LRF;
			end else begin
				ostat_q <= ST_OK;
			end
		end
	end

	assign result_out.valid       = ov_q;
	assign result_out.pixel_index = opix_q;
	assign result_out.disparity   = odisp_q;
	assign result_out.status      = ostat_q;
	assign result_out.last_of_row = olast_q;

endmodule

`default_nettype wire

[src/stw_chk.sv]
// stw_chk: port-level checker for stereo_wta_lr_check, with its bind statement
// depends on stw_pkg for field widths
`default_nettype none

module stw_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic                                 in_row_last,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic        [stw_pkg::PIX_W-1:0]     out_pixel_index,
	input wire logic signed [stw_pkg::DISP_W-1:0]    out_disparity,
	input wire logic        [stw_pkg::STAT_W-1:0]    out_status,
	input wire logic                                 out_last
);
	import stw_pkg::*;

	// a row_last beat starts the scan, loading stops
	a_scan_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_row_last |=> !in_ready)
		else $error("input still ready after row_last beat");

	// an ordinary cost beat keeps the block loading
	a_load_continues: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_row_last |=> in_ready)
		else $error("input dropped ready in mid row");

	// a new result is handed over from the scan, never while loading
	a_result_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while loading");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel_index)
			&& $stable(out_disparity) && $stable(out_status) && $stable(out_last))
		else $error("stalled result beat changed");

endmodule

bind stereo_wta_lr_check stw_chk u_stw_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (cost_in.valid),
	.in_ready       (cost_in.ready),
	.in_row_last    (cost_in.row_last),
	.out_valid      (result_out.valid),
	.out_ready      (result_out.ready),
	.out_pixel_index(result_out.pixel_index),
	.out_disparity  (result_out.disparity),
	.out_status     (result_out.status),
	.out_last       (result_out.last_of_row)
);

`default_nettype wire

[tb/tb.sv]
// tb: self-checking bench for stereo_wta_lr_check, scanline cost load and disparity pick
// depends on stw_pkg and stw_ifs; drives cost beats and apb writes, checks result beats
// against a scanline predictor kept in step with every accepted cost beat
`timescale 1ns / 100ps

module tb;
	import stw_pkg::*;

	localparam int MAXW        = 64;
	localparam int NUM_D       = 64;
	localparam int SETTLE      = 16;
	localparam int DRAIN       = 60;
	localparam int HOLD_CYCLES = 600;
	localparam int N_RANDOM    = 500;
	localparam int N_DIR       = 33;

	// one expected result beat
	typedef struct {
		logic [PIX_W-1:0]  pix;
		logic [DISP_W-1:0] disp;
		logic [STAT_W-1:0] stat;
		logic              last;
	} pixel_verdict_t;

	// one row of the directed table: a register write or a cost beat
	typedef struct {
		bit                is_reg;
		logic [1:0]        idx;
		int                val;
		logic [COST_W-1:0] cost;
		bit                last;
		bit                typed;
		int                t_disp;
		logic [STAT_W-1:0] t_stat;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	stw_in_if  cost_if();
	stw_out_if res_if();

	stereo_wta_lr_check u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cost_in    (cost_if.sink),
		.result_out (res_if.source),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #10 clk = ~clk;

	// predictor state: cost store, which entries hold data, load position, registers
	logic [COST_W-1:0] cost_mem [MAXW*NUM_D];
	bit                cost_seen [MAXW*NUM_D];
	int                load_col  = 0;
	int                load_slot = 0;
	int                cfg_min   = -30;
	int                cfg_max   = 30;
	int                cfg_width = 64;

	pixel_verdict_t expected_pixels [$];
	int             errs = 0;

	// pacing knobs shared by the sender, the receiver and the phase loop
	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;

	// hand-typed result for the final pixel of a directed row
	bit                typed_on   = 1'b0;
	int                typed_disp = 0;
	logic [STAT_W-1:0] typed_stat = ST_OK;

	logic [1:0] reg_list [3] = '{REG_MIN_DISP, REG_MAX_DISP, REG_ROW_WIDTH};
	int         reg_rst  [3] = '{-30, 30, 64};

	dir_row_t dir_tab [N_DIR];

	// number of disparities searched: empty range keeps min only, wide range saturates
	function automatic int search_span();
		int hi;
		hi = cfg_max;
		if (hi < cfg_min) hi = cfg_min;
		if (hi - cfg_min + 1 > NUM_D) hi = cfg_min + NUM_D - 1;
		return hi - cfg_min + 1;
	endfunction

	// row width clamped to 1..MAXW
	function automatic int row_len();
		int w;
		w = cfg_width;
		if (w < 1) w = 1;
		if (w > MAXW) w = MAXW;
		return w;
	endfunction

	// store one cost beat; on row_last pick the winner of every pixel and queue the verdicts
	function automatic void load_and_select(input logic [COST_W-1:0] c, input logic lst);
		int sp, w, x, k, kb, i, kk, r, lo, hi, dsp;
		logic [COST_W-1:0] best;
		logic [STAT_W-1:0] st;
		pixel_verdict_t v;
		sp = search_span();
		w  = row_len();
		// position outside the current row or span restarts the row
		if (load_col >= w || load_slot >= sp) begin
			load_col  = 0;
			load_slot = 0;
		end
		cost_mem[load_col*NUM_D + load_slot]  = c;
		cost_seen[load_col*NUM_D + load_slot] = 1'b1;
		load_slot++;
		if (load_slot >= sp) begin
			load_slot = 0;
			load_col++;
			if (load_col >= w) load_col = 0;
		end
		if (!lst) return;
		for (x = 0; x < w; x++) begin
			// cheapest disparity, first one wins among equals
			kb   = 0;
			best = cost_mem[x*NUM_D];
			for (k = 1; k < sp; k++)
				if (cost_mem[x*NUM_D + k] < best) begin
					best = cost_mem[x*NUM_D + k];
					kb   = k;
				end
			dsp = cfg_min + kb;
			// any other disparity with the very same cost makes it ambiguous
			st = ST_OK;
			for (k = 0; k < sp; k++)
				if (k != kb && cost_mem[x*NUM_D + k] == best) st = ST_TIE;
			// left pixels landing on the same right column must not be strictly cheaper
			if (st == ST_OK) begin
				r  = x + dsp;
				lo = r - (cfg_min + sp - 1);
				hi = r - cfg_min;
				if (lo < 0) lo = 0;
				if (hi > w - 1) hi = w - 1;
				for (i = lo; i <= hi; i++) begin
					kk = r - i - cfg_min;
					if (kk >= 0 && kk < sp && cost_mem[i*NUM_D + kk] < best) st = ST_LRF;
				end
			end
			v.pix  = x[PIX_W-1:0];
			v.disp = dsp[DISP_W-1:0];
			v.stat = st;
			v.last = (x == w - 1);
			expected_pixels.push_back(v);
		end
		load_col  = 0;
		load_slot = 0;
	endfunction

	// true when a row_last on the next beat reads only entries written since reset
	function automatic bit row_closable();
		int sp, w, p, d, x, k;
		sp = search_span();
		w  = row_len();
		p  = load_col;
		d  = load_slot;
		if (p >= w || d >= sp) begin
			p = 0;
			d = 0;
		end
		for (x = 0; x < w; x++)
			for (k = 0; k < sp; k++)
				if (!cost_seen[x*NUM_D + k] && !(x == p && k == d)) return 1'b0;
		return 1'b1;
	endfunction

	// cost beats still missing before the row is complete
	function automatic int slots_left();
		int sp, w, p, d;
		sp = search_span();
		w  = row_len();
		p  = load_col;
		d  = load_slot;
		if (p >= w || d >= sp) begin
			p = 0;
			d = 0;
		end
		return w*sp - (p*sp + d);
	endfunction

	// mostly tiny costs so ties and cross-check hits are frequent
	function automatic logic [COST_W-1:0] pick_cost();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 55) return COST_W'($urandom_range(6));
		if (sel < 80) return COST_W'($urandom);
		if (sel < 90) return {COST_W{1'b1}} - COST_W'($urandom_range(3));
		return 16'h8000 + COST_W'($urandom_range(2));
	endfunction

	// one cost beat, entered and left at a falling edge; valid stays up into the next beat
	task automatic send_cost(input logic [COST_W-1:0] c, input logic lst);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cost_if.valid <= 1'b0;
			@(negedge clk);
		end
		cost_if.valid    <= 1'b1;
		cost_if.cost     <= c;
		cost_if.row_last <= lst;
		do @(posedge clk); while (!cost_if.ready);
		@(negedge clk);
	endtask

	task automatic read_reg(input logic [1:0] idx, output logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// register write while idle, then read back; the sender pauses here until the
	// result queue is empty and the block has had time to leave its emit step
	task automatic set_reg(input logic [1:0] idx, input int val);
		logic [31:0] rd;
		logic signed [DISP_W-1:0] v7;
		cost_if.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		v7 = val[6:0];
		case (idx)
			REG_MIN_DISP:  cfg_min = v7;
			REG_MAX_DISP:  cfg_max = v7;
			REG_ROW_WIDTH: cfg_width = val[6:0];
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		read_reg(idx, rd);
		if (rd[6:0] !== val[6:0]) begin
			$error("register %0d: expected %0d, got %0d", idx, val[6:0], rd[6:0]);
			errs++;
		end
	endtask

	// predictor follows every accepted cost beat
	always @(posedge clk) begin
		pixel_verdict_t t;
		if (arst_n && cost_if.valid && cost_if.ready) begin
			load_and_select(cost_if.cost, cost_if.row_last);
			// directed rows may pin the final pixel to a value read off by hand
			if (cost_if.row_last && typed_on) begin
				t      = expected_pixels.pop_back();
				t.disp = typed_disp[DISP_W-1:0];
				t.stat = typed_stat;
				expected_pixels.push_back(t);
			end
		end
	end

	// result beats against the oldest expectation
	always @(posedge clk) begin
		pixel_verdict_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_pixels.size() == 0) begin
				$error("result beat with none expected: pixel_index %0d", res_if.pixel_index);
				errs++;
			end else begin
				want = expected_pixels.pop_front();
				if (res_if.pixel_index !== want.pix) begin
					$error("pixel_index: expected %0d, got %0d", want.pix, res_if.pixel_index);
					errs++;
				end
				if (res_if.disparity !== want.disp) begin
					$error("disparity: expected %0d, got %0d", $signed(want.disp),
						res_if.disparity);
					errs++;
				end
				if (res_if.status !== want.stat) begin
					$error("status: expected %0d, got %0d", want.stat, res_if.status);
					errs++;
				end
				if (res_if.last_of_row !== want.last) begin
					$error("last_of_row: expected %0d, got %0d", want.last,
						res_if.last_of_row);
					errs++;
				end
			end
		end
	end

	// receiver: random stalls, or one long hold-off counted here when asked
	initial begin
		int held;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_if.ready <= 1'b0;
				for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
			end else begin
				res_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// hard stop in case the block hangs
	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		logic [31:0] rd;
		int n, j, ph, ph_beats, ph_goal, rand_beats, left, full, sel, lo, hi, wd;
		bit end_row;

		cost_if.valid    = 1'b0;
		cost_if.cost     = '0;
		cost_if.row_last = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		arst_n  = 1'b0;

		// directed rows: small spans, cost extremes, ties, cross-check failure,
		// empty range and the disparity extremes
		dir_tab = '{
			'{1, REG_MIN_DISP,   0, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_MAX_DISP,   1, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_ROW_WIDTH,  1, 16'd0,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd5,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd3,     1, 1,   1, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd7,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd7,     1, 1,   0, ST_TIE},
			'{0, REG_MIN_DISP,   0, 16'hFFFF,  0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'h0000,  1, 1,   1, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'h0000,  0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'hFFFF,  1, 1,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'hFFFF,  0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'hFFFF,  1, 1,   0, ST_TIE},
			'{1, REG_MIN_DISP,   5, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_MAX_DISP,  -5, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_ROW_WIDTH,  2, 16'd0,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd9,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd4,     1, 1,   5, ST_OK},
			'{1, REG_MIN_DISP,  -1, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_MAX_DISP,   0, 16'd0,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd9,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd1,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd2,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd10,    1, 1,  -1, ST_LRF},
			'{1, REG_MIN_DISP, -63, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_MAX_DISP, -62, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_ROW_WIDTH,  1, 16'd0,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd4,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd8,     1, 1, -63, ST_OK},
			'{1, REG_MIN_DISP,  62, 16'd0,     0, 0,   0, ST_OK},
			'{1, REG_MAX_DISP,  63, 16'd0,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd8,     0, 0,   0, ST_OK},
			'{0, REG_MIN_DISP,   0, 16'd4,     1, 1,  63, ST_OK}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// register values right after reset
		for (j = 0; j < 3; j++) begin
			read_reg(reg_list[j], rd);
			if (rd[6:0] !== reg_rst[j][6:0]) begin
				$error("register %0d after reset: expected %0d, got %0d", reg_list[j],
					reg_rst[j], rd[6:0]);
				errs++;
			end
		end

		for (n = 0; n < N_DIR; n++) begin
			if (dir_tab[n].is_reg) begin
				set_reg(dir_tab[n].idx, dir_tab[n].val);
			end else begin
				typed_on   = dir_tab[n].typed;
				typed_disp = dir_tab[n].t_disp;
				typed_stat = dir_tab[n].t_stat;
				send_cost(dir_tab[n].cost, dir_tab[n].last);
			end
		end
		typed_on = 1'b0;

		// random phases: the first five pin fixed settings (the first four the extremes), the rest
		// draw settings at random; a phase may end mid-row so the next write lands mid-row
		ph         = 0;
		rand_beats = 0;
		while (rand_beats < N_RANDOM) begin
			case (ph)
				0: begin lo = -63; hi = 63;  wd = 1;   end  // span saturates at 64
				1: begin lo = 0;   hi = 0;   wd = 64;  end  // widest row, one disparity
				2: begin lo = 10;  hi = -10; wd = 0;   end  // empty range, width clamps up
				3: begin lo = 5;   hi = 5;   wd = 127; end  // width clamps down
				4: begin lo = -3;  hi = 3;   wd = 5;   end
				default: begin
					lo  = int'($urandom_range(126)) - 63;
					wd  = $urandom_range(6, 1);
					sel = $urandom_range(99);
					if (sel < 60) hi = lo + int'($urandom_range(5));
					else if (sel < 80) hi = lo - 1 - int'($urandom_range(9));
					else begin
						hi = 63;
						wd = 1;
					end
					if (hi > 63) hi = 63;
					if (hi < -63) hi = -63;
				end
			endcase
			set_reg(REG_MIN_DISP, lo);
			set_reg(REG_MAX_DISP, hi);
			set_reg(REG_ROW_WIDTH, wd);

			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 54; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 54; end
				default: begin send_idle_pct = 11; stall_pct = 11; end
			endcase

			// wide row with the receiver held off: the scan stalls on its first
			// result while the next row is already being offered
			ph_goal = 40;
			if (ph == 1) begin
				hold_req = 1'b1;
				ph_goal  = 130;
			end

			ph_beats = 0;
			while (ph_beats < ph_goal) begin
				left = slots_left();
				full = row_len() * search_span();
				sel  = $urandom_range(99);
				if (sel < 75) begin
					n       = left;  // complete row
					end_row = 1'b1;
				end else if (sel < 85) begin
					n       = $urandom_range(left, 1);  // short row
					end_row = 1'b1;
				end else if (sel < 93) begin
					n       = left + $urandom_range(full, 1);  // overfull row, wraps
					end_row = 1'b1;
				end else begin
					n       = $urandom_range(left, 1);  // fragment, no row_last
					end_row = 1'b0;
				end
				for (j = 0; j < n; j++)
					send_cost(pick_cost(), end_row && j == n - 1 && row_closable());
				ph_beats += n;
			end
			rand_beats += ph_beats;
			ph++;
		end

		// all beats in: wait for the last results, then a little longer for strays
		cost_if.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errs == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
